/* sv/lss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and codes for the LIFO stack with search.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int WORD_W = 32;
    localparam int POS_W  = 6;

    typedef logic [1:0]               t_kind;
    typedef logic [1:0]               t_status;
    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [POS_W-1:0]         t_pos;

    localparam t_kind K_PUSH   = 2'd0;
    localparam t_kind K_POP    = 2'd1;
    localparam t_kind K_SEARCH = 2'd2;
    localparam t_kind K_DUMP   = 2'd3;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_EMPTY    = 2'd1;
    localparam t_status ST_OVERFLOW = 2'd2;
    localparam t_status ST_NOTFOUND = 2'd3;

endpackage

/* sv/lss_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_in_if / lss_out_if
// Valid/ready channels for stack operations and their results.
// ----------------------------------------------------------------------------
interface lss_in_if;
    import lss_pkg::*;

    logic  valid;
    logic  ready;
    t_kind kind;
    t_word value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface lss_out_if;
    import lss_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_word   word;
    t_pos    position;
    logic    last;

    modport source (output valid, output status, output word, output position,
                    output last, input ready);
    modport sink   (input valid, input status, input word, input position,
                    input last, output ready);
endinterface

/* sv/lifo_stack_with_search.sv */
`timescale 1ns / 1ps
// Push and every error go straight into the output register; pop first reads the memory
//   (one memory read), then loads the read word into the output register from S_POP.
// Search walks the memory one entry per cycle from the top.
// Dump gives one item per cycle from the top while the output is not held by back-pressure.
// One push per cycle while the output is not held; the next item waits for pop, search and dump to finish.
// Reset clears the entry count and the control state; the memory is not cleared.
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Bounded LIFO stack of signed words in a single-port synchronous memory,
// with search from the top and dump of all entries.
// ----------------------------------------------------------------------------
module lifo_stack_with_search #(
    parameter int DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lss_in_if.sink    i_in,
    lss_out_if.source o_out
);
    import lss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_POP    = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_DUMP   = 2'd3;

    t_word mem [DEPTH];
    t_word r_rdata;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_idx, n_idx;
    t_word         r_key, n_key;

    logic    r_out_valid, n_out_valid;
    t_status r_status, n_status;
    t_word   r_word, n_word;
    t_pos    r_pos, n_pos;
    logic    r_last, n_last;

    logic          w_in_ready;
    logic          w_accept;
    logic          w_out_free;
    logic          w_full;
    logic          w_empty;
    logic [CW-1:0] w_cnt_m1;
    logic [AW-1:0] w_top;
    logic          w_wr_en;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in.valid && w_in_ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_cnt_m1   = r_count - CW'(1);
    assign w_top      = w_cnt_m1[AW-1:0];

    assign i_in.ready     = w_in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_status;
    assign o_out.word     = r_word;
    assign o_out.position = r_pos;
    assign o_out.last     = r_last;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_idx       = r_idx;
        n_key       = r_key;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_word      = r_word;
        n_pos       = r_pos;
        n_last      = r_last;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_addr - AW'(1);

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_word      = '0;
                    n_pos       = '0;
                    n_last      = 1'b1;
                    case (i_in.kind)
                        K_PUSH: begin
                            if (w_full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                w_wr_en  = 1'b1;
                                n_count  = r_count + CW'(1);
                                n_status = ST_OK;
                                n_word   = i_in.value;
                            end
                        end
                        K_POP: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                w_rd_en     = 1'b1;
                                w_rd_addr   = w_top;
                                n_count     = w_cnt_m1;
                                n_state     = S_POP;
                            end
                        end
                        K_SEARCH: begin
                            if (w_empty) begin
                                n_status = ST_NOTFOUND;
                            end else begin
                                n_out_valid = 1'b0;
                                w_rd_en     = 1'b1;
                                w_rd_addr   = w_top;
                                n_addr      = w_top;
                                n_idx       = '0;
                                n_key       = i_in.value;
                                n_state     = S_SEARCH;
                            end
                        end
                        default: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                w_rd_en     = 1'b1;
                                w_rd_addr   = w_top;
                                n_addr      = w_top;
                                n_idx       = '0;
                                n_state     = S_DUMP;
                            end
                        end
                    endcase
                end
            end
            S_POP: begin
                n_out_valid = 1'b1;
                n_status    = ST_OK;
                n_word      = r_rdata;
                n_pos       = '0;
                n_last      = 1'b1;
                n_state     = S_IDLE;
            end
            S_SEARCH: begin
                if (r_rdata == r_key) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_word      = r_rdata;
                    n_pos       = POS_W'(r_idx);
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end else if (r_addr == '0) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_NOTFOUND;
                    n_word      = '0;
                    n_pos       = '0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    w_rd_en = 1'b1;
                    n_addr  = r_addr - AW'(1);
                    n_idx   = r_idx + AW'(1);
                end
            end
            default: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_word      = r_rdata;
                    n_pos       = POS_W'(r_idx);
                    n_last      = (r_addr == '0);
                    if (r_addr == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        w_rd_en = 1'b1;
                        n_addr  = r_addr - AW'(1);
                        n_idx   = r_idx + AW'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_count[AW-1:0]] <= i_in.value;
        end
        if (w_rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_status <= n_status;
        r_word   <= n_word;
        r_pos    <= n_pos;
        r_last   <= n_last;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.kind == K_PUSH && !w_full) |=>
        (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the stack");

    a_pop_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.kind == K_POP && !w_empty) |=>
        (r_state == S_POP && !r_out_valid))
        else $error("pop did not wait for the memory read");

    a_walk_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH || r_state == S_DUMP) |->
        (CW'(r_idx) + CW'(r_addr) + CW'(1) == r_count))
        else $error("walk index and address out of step");

endmodule

/* test/tb_lifo_stack_with_search.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_search
// Self-checking bench for the LIFO stack: drives push, pop, search and dump
// items with random gaps and back-pressure, predicts every result from its
// own copy of the stack, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_search;
    import lss_pkg::*;

    localparam int DEPTH      = 64;
    localparam int HOLD_LEN   = 150;
    localparam int IDLE_LIMIT = 3000;
    localparam int MIX_LEN    = 10;

    typedef struct {
        t_kind kind;
        t_word value;
        bit    drain;   // offered only once every result is back
        bit    hold;    // receiver holds off once this item is taken
    } stack_op_t;

    typedef struct {
        t_status status;
        t_word   word;
        t_pos    position;
        logic    last;
    } stack_result_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lss_in_if  in_ch();
    lss_out_if out_ch();

    lifo_stack_with_search #(.DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    t_word         model_mem [DEPTH];
    int            model_count = 0;
    stack_result_t expected_results[$];
    stack_op_t     op_queue[$];
    t_word         gen_stack[$];
    stack_op_t     cur_op;
    bit            offering    = 1'b0;
    bit            hold_req    = 1'b0;
    int            fail_count  = 0;
    int            idle_cycles = 0;
    int            tx_gap      = 0;
    int            tx_calm     = 0;
    int            rx_gap      = 0;
    int            rx_calm     = 0;
    int            rx_hold     = 0;

    function automatic void predict_stack_op(t_kind kind, t_word value);
        stack_result_t r;
        int k;
        bit hit;
        r.status   = ST_OK;
        r.word     = '0;
        r.position = '0;
        r.last     = 1'b1;
        hit        = 1'b0;
        case (kind)
            K_PUSH: begin
                if (model_count >= DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    model_mem[model_count] = value;
                    model_count++;
                    r.word = value;
                end
            end
            K_POP: begin
                if (model_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    model_count--;
                    r.word = model_mem[model_count];
                end
            end
            K_SEARCH: begin
                r.status = ST_NOTFOUND;
                for (k = 0; k < model_count && !hit; k++) begin
                    if (model_mem[model_count-1-k] == value) begin
                        hit        = 1'b1;
                        r.status   = ST_OK;
                        r.word     = value;
                        r.position = t_pos'(k);
                    end
                end
            end
            default: begin
                if (model_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (k = 0; k < model_count; k++) begin
                        r.word     = model_mem[model_count-1-k];
                        r.position = t_pos'(k);
                        r.last     = (k == model_count - 1);
                        expected_results.push_back(r);
                    end
                    return;
                end
            end
        endcase
        expected_results.push_back(r);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            calm = $urandom_range(10, 30);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return t_word'($urandom_range(0, 20)) - 10;
            default: return t_word'($urandom);
        endcase
    endfunction

    // keys mostly taken from what is stored at that point
    function automatic t_word pick_key();
        if (gen_stack.size() > 0 && $urandom_range(0, 3) != 0)
            return gen_stack[$urandom_range(0, gen_stack.size() - 1)];
        return rand_word();
    endfunction

    function automatic void add_op(t_kind kind, t_word value, bit drain = 1'b0,
                                   bit hold = 1'b0);
        stack_op_t op;
        op.kind  = kind;
        op.value = value;
        op.drain = drain;
        op.hold  = hold;
        op_queue.push_back(op);
        if (kind == K_PUSH && gen_stack.size() < DEPTH)
            gen_stack.push_back(value);
        else if (kind == K_POP && gen_stack.size() > 0)
            void'(gen_stack.pop_back());
    endfunction

    function automatic void add_mixed(int n);
        int w;
        repeat (n) begin
            w = $urandom_range(0, 99);
            if (w < 40)      add_op(K_PUSH, rand_word());
            else if (w < 65) add_op(K_POP, rand_word());
            else if (w < 85) add_op(K_SEARCH, pick_key());
            else             add_op(K_DUMP, rand_word());
        end
    endfunction

    // sender
    always @(negedge i_clk) begin
        logic nv;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (offering) begin
            nv = 1'b1;
        end else if (tx_gap > 0) begin
            tx_gap--;
            nv = 1'b0;
        end else if (op_queue.size() > 0 &&
                     !(op_queue[0].drain && expected_results.size() > 0)) begin
            cur_op   = op_queue.pop_front();
            offering = 1'b1;
            nv       = 1'b1;
            tx_gap   = pick_gap(tx_calm);
            in_ch.kind  <= cur_op.kind;
            in_ch.value <= cur_op.value;
        end else begin
            nv = 1'b0;
        end
        if (!nv) begin
            in_ch.kind  <= t_kind'($urandom);
            in_ch.value <= t_word'($urandom);
        end
        in_ch.valid <= nv;
    end

    // receiver
    always @(negedge i_clk) begin
        logic nr;
        if (hold_req) begin
            hold_req = 1'b0;
            rx_hold  = HOLD_LEN;
        end
        if (!i_rst_n) begin
            nr = 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            nr = 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            nr = 1'b0;
        end else begin
            nr = 1'b1;
        end
        out_ch.ready <= nr;
    end

    // accept, predict, check, watchdog
    always @(posedge i_clk) begin
        stack_result_t want;
        bit moved;
        moved = 1'b0;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            predict_stack_op(in_ch.kind, in_ch.value);
            if (cur_op.hold) hold_req = 1'b1;
            offering = 1'b0;
            moved    = 1'b1;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            moved  = 1'b1;
            rx_gap = pick_gap(rx_calm);
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d word 0x%0h position %0d last %0b",
                       out_ch.status, out_ch.word, out_ch.position, out_ch.last);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(want.status), 32'(out_ch.status));
                check_field("word", want.word, out_ch.word);
                check_field("position", 32'(want.position), 32'(out_ch.position));
                check_field("last", 32'(want.last), 32'(out_ch.last));
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_lifo_stack_with_search NOT OK");
            $finish;
        end
    end

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.kind   = K_PUSH;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;

        // empty-stack errors, extremes, duplicates, dump, underflow
        add_op(K_POP, '0);
        add_op(K_SEARCH, '0);
        add_op(K_DUMP, '0);
        add_op(K_PUSH, 32'h7fff_ffff);
        add_op(K_PUSH, 32'h8000_0000);
        add_op(K_PUSH, '0);
        add_op(K_PUSH, '1);
        add_op(K_SEARCH, '1);
        add_op(K_SEARCH, 32'h7fff_ffff);
        add_op(K_SEARCH, 32'h1234_5678);
        add_op(K_PUSH, 5);
        add_op(K_PUSH, 5);
        add_op(K_SEARCH, 5);
        add_op(K_DUMP, '0, 1'b1);
        add_op(K_SEARCH, 32'h8000_0000);
        repeat (7) add_op(K_POP, '1);

        add_op(K_PUSH, rand_word(), 1'b1);
        add_mixed(MIX_LEN);

        // fill to overflow under a long receiver stall, then walk the full stack
        add_op(K_PUSH, rand_word(), 1'b0, 1'b1);
        while (gen_stack.size() < DEPTH) add_op(K_PUSH, rand_word());
        repeat ($urandom_range(1, 3)) add_op(K_PUSH, rand_word());
        add_op(K_SEARCH, gen_stack[0]);
        add_op(K_SEARCH, pick_key());
        add_op(K_DUMP, rand_word());
        add_op(K_POP, rand_word(), 1'b1);
        add_mixed(MIX_LEN);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (op_queue.size() > 0 || offering) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);

        if (fail_count == 0)
            $display("tb_lifo_stack_with_search OK");
        else
            $display("tb_lifo_stack_with_search NOT OK");
        $finish;
    end

endmodule
